>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file oets_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/oets_pkg.sv
package oets_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr;
        logic pair_r;
        logic pair_l;
        logic shift;
    } t_cell_ctl;

endpackage

>>> rtl/core/oets_cell.sv
module oets_cell #(
    parameter int VALUE_BITS = 10
) (
    input  logic                  i_clk,
    input  oets_pkg::t_cell_ctl   i_ctl,
    input  logic [VALUE_BITS-1:0] i_din,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    output logic [VALUE_BITS-1:0] o_val
);
    import oets_pkg::*;

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.wr) begin
            n_val = i_din;
        end else if (i_ctl.shift) begin
            n_val = i_right;
        end else if (i_ctl.pair_r) begin
            if (r_val > i_right) begin
                n_val = i_right;
            end
        end else if (i_ctl.pair_l) begin
            if (i_left > r_val) begin
                n_val = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

>>> rtl/core/odd_even_transposition_sort_top.sv
// Sorts sets of up to CAPACITY unsigned values with a row of compare-exchange cells.
// Input beats load one per cycle while o_in_ready is high; the beat marked last closes
// the set (beats arriving with the row full are dropped and flag overflow on every
// result of that set). For a set of n loaded values the row then runs n transposition
// phases, one per cycle, and shifts the values out through a registered output stage
// in ascending order, one beat per cycle when the sink is ready, the final one marked
// last. o_in_ready is low from the last input beat until the final result enters the
// output register.
module odd_even_transposition_sort_top #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_last_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_sorted_value,
    output logic                  o_last_out,
    output logic                  o_overflow
);
    import oets_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_phase;
    logic [CNT_W-1:0]      n_phase;
    logic                  r_drop;
    logic                  n_drop;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [VALUE_BITS-1:0] r_out_val;
    logic [VALUE_BITS-1:0] n_out_val;
    logic                  r_out_last;
    logic                  n_out_last;
    logic                  r_out_ovf;
    logic                  n_out_ovf;

    logic                  in_acc;
    logic                  out_free;
    logic                  room;
    logic                  is_final;
    logic                  sorting;
    logic                  shifting;

    t_cell_ctl             cell_ctl [CAPACITY];
    logic [VALUE_BITS-1:0] cell_val [CAPACITY];

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign room       = (r_count < CNT_W'(CAPACITY));
    assign is_final   = (r_phase == r_count - CNT_W'(1));
    assign sorting    = (r_state == ST_SORT);
    assign shifting   = (r_state == ST_EMIT) && out_free;

    // per-cell control and the row of cells
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic [VALUE_BITS-1:0] left_val;
        logic [VALUE_BITS-1:0] right_val;

        always_comb begin
            cell_ctl[j].wr     = in_acc && room && (r_count == CNT_W'(j));
            cell_ctl[j].shift  = shifting;
            cell_ctl[j].pair_r = sorting && (r_phase[0] == 1'(j))
                                 && (CNT_W'(j + 1) < r_count);
            cell_ctl[j].pair_l = sorting && (j > 0) && (r_phase[0] != 1'(j))
                                 && (CNT_W'(j) < r_count);
        end

        if (j == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[j-1];
        end

        if (j == CAPACITY - 1) begin : g_end
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[j+1];
        end

        oets_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[j]),
            .i_din  (i_value),
            .i_left (left_val),
            .i_right(right_val),
            .o_val  (cell_val[j])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_phase     = r_phase;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = ST_SORT;
                        n_phase = '0;
                    end
                end
            end
            ST_SORT: begin
                if (is_final) begin
                    n_state = ST_EMIT;
                    n_phase = '0;
                end else begin
                    n_phase = r_phase + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = cell_val[0];
                    n_out_last  = is_final;
                    n_out_ovf   = r_drop;
                    n_phase     = r_phase + CNT_W'(1);
                    if (is_final) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_phase = '0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_phase     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_val;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

>>> rtl/core/oets_chk.sv
`include "assert_macros.svh"

module oets_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_last_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_last_out,
    input logic o_overflow
);

    // output beat holds while stalled
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // closing beat stops input intake
    `ASSERT_NEXT(a_last_stops_in, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_in,
                 !o_in_ready)

    // no intake while a set is still being emitted
    `ASSERT_NOW(a_no_in_mid_set, i_clk, i_rst_n, o_out_valid && !o_last_out, !o_in_ready)

    // a set streams without gaps and keeps one overflow flag
    `ASSERT_NEXT(a_set_steady, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_out,
                 o_out_valid && (o_overflow == $past(o_overflow)))

endmodule

bind odd_even_transposition_sort_top oets_chk u_oets_chk (.*);
